FILE: rtl/sal_pkg.sv
// Shared types and codes for the shifting array list.
package sal_pkg;

   // Operation codes carried in the func field
   typedef enum logic [2:0] {
      OP_APPEND    = 3'd0,
      OP_INSERT    = 3'd1,
      OP_POP       = 3'd2,
      OP_REMOVE_AT = 3'd3,
      OP_READ      = 3'd4
   } func_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // Controller sequence
   typedef enum logic {
      S_IDLE,
      S_FOLD
   } state_type;

   // Broadcast command for the row of cells
   typedef struct packed {
      logic ins;    // open a gap at the target and load the new word
      logic del;    // close the gap at the target, pulling from the right
      logic rd;     // drive the target entry onto the read bus
   } cell_ctl_type;

   localparam int unsigned WORD_W   = 64;
   localparam int unsigned FUNC_W   = 3;
   localparam int unsigned POS_W    = 7;
   localparam int unsigned COUNT_W  = 7;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned GROUP    = 8;

endpackage

FILE: rtl/sal_req_if.sv
// Request channel: operation, position and word to store.
interface sal_req_if;
   logic                            valid;
   logic                            ready;
   logic [sal_pkg::FUNC_W-1:0]      func;
   logic [sal_pkg::POS_W-1:0]       position;
   logic [sal_pkg::WORD_W-1:0]      word_in;

   modport source (output valid, output func, output position, output word_in,
                   input ready);
   modport sink   (input valid, input func, input position, input word_in,
                   output ready);
endinterface

FILE: rtl/sal_rsp_if.sv
// Response channel: read word, count, flags and status.
interface sal_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sal_pkg::WORD_W-1:0]      word_out;
   logic [sal_pkg::COUNT_W-1:0]     count;
   logic                            is_empty;
   logic                            is_full;
   logic [sal_pkg::STATUS_W-1:0]    status;

   modport source (output valid, output word_out, output count, output is_empty,
                   output is_full, output status, input ready);
   modport sink   (input valid, input word_out, input count, input is_empty,
                   input is_full, input status, output ready);
endinterface

FILE: rtl/sal_cell.sv
// One list slot: holds an entry and trades it with its neighbors.
module sal_cell #(
   parameter int unsigned INDEX = 0,
   parameter int unsigned IDX_W = 6
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sal_pkg::cell_ctl_type         ctl,
   input  logic [IDX_W-1:0]              target,
   input  logic [sal_pkg::WORD_W-1:0]    word,
   input  logic [sal_pkg::WORD_W-1:0]    left,
   input  logic [sal_pkg::WORD_W-1:0]    right,
   output logic [sal_pkg::WORD_W-1:0]    q,
   output logic [sal_pkg::WORD_W-1:0]    rd
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   logic [sal_pkg::WORD_W-1:0] entry_ff;
   logic [sal_pkg::WORD_W-1:0] entry_in;
   logic                       at_target;
   logic                       above_target;

   assign at_target    = (target == MY_IDX);
   assign above_target = (MY_IDX > target);

   // Pick the next entry: load, shift up, shift down or hold
   always_comb begin
      entry_in = entry_ff;
      if (ctl.ins) begin
         if (at_target) begin
            entry_in = word;
         end else if (above_target) begin
            entry_in = left;
         end
      end else if (ctl.del) begin
         if (at_target || above_target) begin
            entry_in = right;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign q  = entry_ff;
   assign rd = (ctl.rd && at_target) ? entry_ff : '0;

endmodule

FILE: rtl/sal_fold.sv
// Registered OR tree that merges the gated read outputs of all cells.
module sal_fold #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                          clock,
   input  logic [sal_pkg::WORD_W-1:0]    rd [CAPACITY],
   output logic [sal_pkg::WORD_W-1:0]    merged
);

   localparam int unsigned NGROUP = (CAPACITY + sal_pkg::GROUP - 1) / sal_pkg::GROUP;

   logic [sal_pkg::WORD_W-1:0] group_ff [NGROUP];
   logic [sal_pkg::WORD_W-1:0] group_in [NGROUP];

   // OR each group of eight cells
   always_comb begin
      for (int g = 0; g < NGROUP; g++) begin
         group_in[g] = '0;
         for (int j = 0; j < sal_pkg::GROUP; j++) begin
            if (g * sal_pkg::GROUP + j < CAPACITY) begin
               group_in[g] = group_in[g] | rd[g * sal_pkg::GROUP + j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NGROUP; g++) begin
         group_ff[g] <= group_in[g];
      end
   end

   // Merge the group registers
   always_comb begin
      merged = '0;
      for (int g = 0; g < NGROUP; g++) begin
         merged = merged | group_ff[g];
      end
   end

endmodule

FILE: rtl/shifting_array_list_unit.sv
// Shifting array list: a row of CAPACITY cells, one entry each, that shift together for insert
// and remove. When a request word is accepted, the cells update and the gated read outputs
// are captured in groups of eight; in the fold state that follows, the groups are merged into
// the response register. A new request is taken only in the idle state, once the response
// register is empty or being drained, so no new word is taken while the last one is still
// in the fold state. No clearing pass follows reset.
module shifting_array_list_unit #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic          clock,
   input  logic          reset,
   sal_req_if.sink       req_port,
   sal_rsp_if.source     rsp_port
);

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CMP_W = (CNT_W > sal_pkg::POS_W) ? CNT_W : sal_pkg::POS_W;
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   sal_pkg::state_type          state_ff, state_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   sal_pkg::status_type         status_ff, status_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [sal_pkg::WORD_W-1:0]  word_out_ff;
   logic [sal_pkg::COUNT_W-1:0] count_out_ff;
   logic                        empty_out_ff, full_out_ff;
   sal_pkg::status_type         status_out_ff;

   logic                        accept;
   logic                        load_rsp;
   sal_pkg::func_type           func;
   logic [CMP_W-1:0]            pos_ext;
   logic [CMP_W-1:0]            n_ext;
   sal_pkg::cell_ctl_type       ctl;
   logic [IDX_W-1:0]            target;

   logic [sal_pkg::WORD_W-1:0]  cell_q  [CAPACITY];
   logic [sal_pkg::WORD_W-1:0]  cell_rd [CAPACITY];
   logic [sal_pkg::WORD_W-1:0]  merged;

   assign accept = req_port.valid && req_port.ready;
   assign func   = sal_pkg::func_type'(req_port.func);
   assign pos_ext = CMP_W'(req_port.position);
   assign n_ext   = CMP_W'(count_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sal_pkg::S_IDLE: if (accept) state_in = sal_pkg::S_FOLD;
         sal_pkg::S_FOLD: state_in = sal_pkg::S_IDLE;
         default:         state_in = sal_pkg::S_IDLE;
      endcase
   end

   // Outputs of the sequence
   always_comb begin
      req_port.ready = 1'b0;
      load_rsp       = 1'b0;
      unique case (state_ff)
         sal_pkg::S_IDLE: req_port.ready = !rsp_valid_ff || rsp_port.ready;
         sal_pkg::S_FOLD: load_rsp = 1'b1;
         default:         req_port.ready = 1'b0;
      endcase
   end

   // Decode the operation, check bounds, build the cell command
   always_comb begin
      ctl       = '0;
      target    = IDX_W'(req_port.position);
      count_in  = count_ff;
      status_in = sal_pkg::ST_DONE;
      unique case (func)
         sal_pkg::OP_APPEND: begin
            target = IDX_W'(count_ff);
            if (count_ff >= CAP_CNT) begin
               status_in = sal_pkg::ST_FULL;
            end else begin
               ctl.ins  = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         sal_pkg::OP_INSERT: begin
            if (pos_ext > n_ext) begin
               status_in = sal_pkg::ST_RANGE;
            end else if (count_ff >= CAP_CNT) begin
               status_in = sal_pkg::ST_FULL;
            end else begin
               ctl.ins  = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         sal_pkg::OP_POP: begin
            target = IDX_W'(count_ff - 1'b1);
            if (count_ff == '0) begin
               status_in = sal_pkg::ST_EMPTY;
            end else begin
               ctl.del  = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         sal_pkg::OP_REMOVE_AT: begin
            if (count_ff == '0) begin
               status_in = sal_pkg::ST_EMPTY;
            end else if (pos_ext >= n_ext) begin
               status_in = sal_pkg::ST_RANGE;
            end else begin
               ctl.del  = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         sal_pkg::OP_READ: begin
            if (pos_ext >= n_ext) begin
               status_in = sal_pkg::ST_RANGE;
            end else begin
               ctl.rd = 1'b1;
            end
         end
         default: ;
      endcase
      // Drop everything unless a word is taken
      if (!accept) begin
         ctl       = '0;
         count_in  = count_ff;
         status_in = status_ff;
      end
   end

   // Row of cells; the ends see empty slots
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [sal_pkg::WORD_W-1:0] left_w;
      logic [sal_pkg::WORD_W-1:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_q[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_q[i+1];
      end
      sal_cell #(
         .INDEX (i),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .ctl    (ctl),
         .target (target),
         .word   (req_port.word_in),
         .left   (left_w),
         .right  (right_w),
         .q      (cell_q[i]),
         .rd     (cell_rd[i])
      );
   end

   sal_fold #(
      .CAPACITY (CAPACITY)
   ) u_fold (
      .clock  (clock),
      .rd     (cell_rd),
      .merged (merged)
   );

   // Response valid: set on load, clear when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sal_pkg::S_IDLE;
         count_ff     <= '0;
         status_ff    <= sal_pkg::ST_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the response payload
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         word_out_ff   <= merged;
         count_out_ff  <= sal_pkg::COUNT_W'(count_ff);
         empty_out_ff  <= (count_ff == '0);
         full_out_ff   <= (count_ff >= CAP_CNT);
         status_out_ff <= status_ff;
      end
   end

   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.word_out = word_out_ff;
   assign rsp_port.count    = count_out_ff;
   assign rsp_port.is_empty = empty_out_ff;
   assign rsp_port.is_full  = full_out_ff;
   assign rsp_port.status   = status_out_ff;

endmodule

FILE: verif/shifting_array_list_unit_tb.sv
// Testbench for the shifting array list unit: directed and random list operations checked against a predictor.
`timescale 1ns / 1ps

module shifting_array_list_unit_tb;

   localparam int unsigned CAP            = 64;
   localparam int unsigned ITEM_TARGET    = 1950;
   localparam int unsigned TAIL_ITEMS     = 200;
   localparam int unsigned HOLD_CYCLES    = 250;
   localparam int unsigned HOLD_FIRST     = 600;
   localparam int unsigned HOLD_SPACING   = 700;
   localparam int unsigned DRAIN_CYCLES   = 8;
   localparam int unsigned WATCHDOG_LIMIT = 2000;

   // Operation codes that the block ignores
   localparam logic [sal_pkg::FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [sal_pkg::FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

   // Traffic mix of one random segment
   localparam int MIX_GROW   = 0;
   localparam int MIX_SHRINK = 1;
   localparam int MIX_BOTH   = 2;

   typedef struct {
      logic [sal_pkg::FUNC_W-1:0] func;
      logic [sal_pkg::POS_W-1:0]  position;
      logic [sal_pkg::WORD_W-1:0] word;
   } list_op_type;

   typedef struct {
      logic [sal_pkg::WORD_W-1:0]  word;
      logic [sal_pkg::COUNT_W-1:0] count;
      logic                        is_empty;
      logic                        is_full;
      sal_pkg::status_type         status;
   } list_rsp_type;

   logic clock = 1'b0;
   logic reset;

   sal_req_if req_if ();
   sal_rsp_if rsp_if ();

   shifting_array_list_unit #(
      .CAPACITY (CAP)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if)
   );

   // Operations waiting to be sent, and results waiting to arrive
   list_op_type  pending_ops[$];
   list_rsp_type predicted_rsp[$];
   list_op_type  cur_op;

   // Predictor state
   logic [sal_pkg::WORD_W-1:0] shadow_entries [CAP];
   int unsigned                shadow_fill;

   // Fill level as seen by the stimulus planner
   int unsigned plan_fill;
   int unsigned ops_planned;

   int unsigned ops_accepted;
   int unsigned rsp_checked;
   int unsigned error_count;
   int unsigned full_seen;
   int unsigned empty_seen;
   int unsigned range_rejects;
   int unsigned full_rejects;
   int unsigned empty_rejects;

   int unsigned send_gap;
   int unsigned send_idle_pct;
   int unsigned rsp_stall;
   int unsigned recv_idle_pct;
   int unsigned next_hold_at;
   int unsigned quiet_cycles;

   // Clock: 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Apply one operation to the predictor and return the result it must produce
   function automatic list_rsp_type apply_list_op(list_op_type op);
      list_rsp_type r;
      int unsigned  n;
      int unsigned  p;
      int unsigned  k;
      r.word   = '0;
      r.status = sal_pkg::ST_DONE;
      n = shadow_fill;
      p = op.position;
      case (op.func)
         sal_pkg::OP_APPEND: begin
            if (n >= CAP) begin
               r.status = sal_pkg::ST_FULL;
            end else begin
               shadow_entries[n] = op.word;
               shadow_fill = n + 1;
            end
         end
         sal_pkg::OP_INSERT: begin
            if (p > n) begin
               r.status = sal_pkg::ST_RANGE;
            end else if (n >= CAP) begin
               r.status = sal_pkg::ST_FULL;
            end else begin
               for (k = n; k > p; k--) shadow_entries[k] = shadow_entries[k-1];
               shadow_entries[p] = op.word;
               shadow_fill = n + 1;
            end
         end
         sal_pkg::OP_POP: begin
            if (n == 0) begin
               r.status = sal_pkg::ST_EMPTY;
            end else begin
               shadow_entries[n-1] = '0;
               shadow_fill = n - 1;
            end
         end
         sal_pkg::OP_REMOVE_AT: begin
            if (n == 0) begin
               r.status = sal_pkg::ST_EMPTY;
            end else if (p >= n) begin
               r.status = sal_pkg::ST_RANGE;
            end else begin
               for (k = p; k + 1 < n; k++) shadow_entries[k] = shadow_entries[k+1];
               shadow_entries[n-1] = '0;
               shadow_fill = n - 1;
            end
         end
         sal_pkg::OP_READ: begin
            if (p >= n) r.status = sal_pkg::ST_RANGE;
            else r.word = shadow_entries[p];
         end
         default: ;
      endcase
      r.count    = shadow_fill[sal_pkg::COUNT_W-1:0];
      r.is_empty = (shadow_fill == 0);
      r.is_full  = (shadow_fill >= CAP);
      return r;
   endfunction

   // Queue one operation and track the fill level it leaves behind
   task automatic plan_op(logic [sal_pkg::FUNC_W-1:0] func, int unsigned position,
                          logic [sal_pkg::WORD_W-1:0] word);
      list_op_type op;
      op.func     = func;
      op.position = position[sal_pkg::POS_W-1:0];
      op.word     = word;
      pending_ops.push_back(op);
      case (func)
         sal_pkg::OP_APPEND: if (plan_fill < CAP) plan_fill++;
         sal_pkg::OP_INSERT: if (position <= plan_fill && plan_fill < CAP) plan_fill++;
         sal_pkg::OP_POP: if (plan_fill > 0) plan_fill--;
         sal_pkg::OP_REMOVE_AT: if (plan_fill > 0 && position < plan_fill) plan_fill--;
         default: ;
      endcase
      if (func < FUNC_SPARE_FIRST) ops_planned++;
   endtask

   // Random operation code between two bounds
   function automatic logic [sal_pkg::FUNC_W-1:0] rand_func(int unsigned lo, int unsigned hi);
      int unsigned v;
      v = $urandom_range(hi, lo);
      return v[sal_pkg::FUNC_W-1:0];
   endfunction

   function automatic logic [sal_pkg::WORD_W-1:0] rand_word();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic int unsigned pick_idle_pct();
      case ($urandom_range(4))
         0, 1: return 0;
         2: return 10;
         3: return 30;
         default: return 50;
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Compare one response word with the oldest prediction
   task automatic check_rsp_word();
      list_rsp_type want;
      if (predicted_rsp.size() == 0) begin
         report_mismatch("response word with no operation outstanding");
         return;
      end
      want = predicted_rsp.pop_front();
      if (rsp_if.word_out !== want.word)
         report_mismatch($sformatf("result %0d word_out %h, expected %h",
                                   rsp_checked, rsp_if.word_out, want.word));
      if (rsp_if.count !== want.count)
         report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                   rsp_checked, rsp_if.count, want.count));
      if (rsp_if.is_empty !== want.is_empty)
         report_mismatch($sformatf("result %0d is_empty %b, expected %b",
                                   rsp_checked, rsp_if.is_empty, want.is_empty));
      if (rsp_if.is_full !== want.is_full)
         report_mismatch($sformatf("result %0d is_full %b, expected %b",
                                   rsp_checked, rsp_if.is_full, want.is_full));
      if (rsp_if.status !== want.status)
         report_mismatch($sformatf("result %0d status %0d, expected %s",
                                   rsp_checked, rsp_if.status, want.status.name()));
      if (want.is_full) full_seen++;
      if (want.is_empty) empty_seen++;
      case (want.status)
         sal_pkg::ST_RANGE: range_rejects++;
         sal_pkg::ST_FULL: full_rejects++;
         sal_pkg::ST_EMPTY: empty_rejects++;
         default: ;
      endcase
      rsp_checked++;
   endtask

   // Reset and known levels on every input from time zero
   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.func      = '0;
      req_if.position  = '0;
      req_if.word_in   = '0;
      rsp_if.ready     = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver: present queued words, predict each one as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         foreach (shadow_entries[i]) shadow_entries[i] = '0;
         shadow_fill   = 0;
         send_gap      = 0;
         send_idle_pct = pick_idle_pct();
      end else begin
         if (req_if.valid && req_if.ready) begin
            predicted_rsp.push_back(apply_list_op(cur_op));
            ops_accepted++;
            if (ops_accepted % 64 == 0) send_idle_pct = pick_idle_pct();
         end
         if (!req_if.valid || req_if.ready) begin
            // Start an idle burst now and then, never in the tail
            if (send_gap == 0 && pending_ops.size() >= TAIL_ITEMS &&
                $urandom_range(99) < send_idle_pct)
               send_gap = $urandom_range(1, 10);
            if (send_gap > 0 || pending_ops.size() == 0) begin
               if (send_gap > 0) send_gap--;
               req_if.valid <= 1'b0;
            end else begin
               cur_op = pending_ops.pop_front();
               req_if.valid    <= 1'b1;
               req_if.func     <= cur_op.func;
               req_if.position <= cur_op.position;
               req_if.word_in  <= cur_op.word;
            end
         end
      end
   end

   // Monitor: check response words, stall in bursts, hold off long twice
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall     = 0;
         recv_idle_pct = pick_idle_pct();
         next_hold_at  = HOLD_FIRST;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            check_rsp_word();
            if (rsp_checked % 64 == 0) recv_idle_pct = pick_idle_pct();
            if (rsp_checked == next_hold_at && pending_ops.size() >= TAIL_ITEMS) begin
               rsp_stall    = HOLD_CYCLES;
               next_hold_at = next_hold_at + HOLD_SPACING;
            end
         end
         if (rsp_stall == 0 && pending_ops.size() >= TAIL_ITEMS &&
             $urandom_range(99) < recv_idle_pct)
            rsp_stall = $urandom_range(1, 10);
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Count cycles in which no word moves on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      quiet_cycles = 0;
      @(negedge reset);
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("Watchdog: no word moved for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, predicted_rsp.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Stimulus and end of run
   initial begin
      int mix;
      int unsigned seg_left;
      int unsigned grow_pct;
      int unsigned shrink_pct;
      int unsigned pick;
      int unsigned pos;
      plan_fill   = 0;
      ops_planned = 0;
      ops_accepted = 0;
      rsp_checked  = 0;
      error_count  = 0;
      full_seen    = 0;
      empty_seen   = 0;
      range_rejects = 0;
      full_rejects  = 0;
      empty_rejects = 0;

      // Directed: rejections on an empty list
      plan_op(sal_pkg::OP_READ, 0, '0);
      plan_op(sal_pkg::OP_POP, 0, '0);
      plan_op(sal_pkg::OP_REMOVE_AT, 0, '0);
      plan_op(sal_pkg::OP_INSERT, 1, 64'h1);
      // Build a short list with extreme words, insert at head, middle and end
      plan_op(sal_pkg::OP_INSERT, 0, '1);
      plan_op(sal_pkg::OP_APPEND, 0, '0);
      plan_op(sal_pkg::OP_APPEND, 0, 64'h8000_0000_0000_0001);
      plan_op(sal_pkg::OP_INSERT, 3, 64'h0123_4567_89ab_cdef);
      plan_op(sal_pkg::OP_INSERT, 1, 64'hfedc_ba98_7654_3210);
      plan_op(sal_pkg::OP_INSERT, 127, 64'h5a5a_5a5a_a5a5_a5a5);
      // Reads inside and past the end
      plan_op(sal_pkg::OP_READ, 0, '0);
      plan_op(sal_pkg::OP_READ, 4, '0);
      plan_op(sal_pkg::OP_READ, 5, '0);
      plan_op(sal_pkg::OP_READ, 127, '1);
      // Removals past the end, then from the middle and the head, and a pop from the end
      plan_op(sal_pkg::OP_REMOVE_AT, 5, '0);
      plan_op(sal_pkg::OP_REMOVE_AT, 127, '0);
      plan_op(sal_pkg::OP_REMOVE_AT, 2, '0);
      plan_op(sal_pkg::OP_REMOVE_AT, 0, '0);
      plan_op(sal_pkg::OP_POP, 0, '0);
      // Ignored codes leave the list alone
      for (int f = FUNC_SPARE_FIRST; f <= FUNC_SPARE_LAST; f++)
         plan_op(f[sal_pkg::FUNC_W-1:0], $urandom_range(127), rand_word());
      plan_op(sal_pkg::OP_READ, 1, '0);
      plan_op(sal_pkg::OP_POP, 0, '0);
      plan_op(sal_pkg::OP_POP, 0, '0);
      plan_op(sal_pkg::OP_POP, 0, '0);
      plan_op(sal_pkg::OP_READ, 0, '0);

      // Random: segments that fill, drain or churn the list
      seg_left = 0;
      mix      = MIX_BOTH;
      while (ops_planned < ITEM_TARGET) begin
         if (seg_left == 0) begin
            mix      = $urandom_range(MIX_BOTH);
            seg_left = $urandom_range(40, 120);
         end
         seg_left--;
         case (mix)
            MIX_GROW: begin grow_pct = 80; shrink_pct = 10; end
            MIX_SHRINK: begin grow_pct = 10; shrink_pct = 80; end
            default: begin grow_pct = 35; shrink_pct = 35; end
         endcase
         pick = $urandom_range(99);
         if (pick < 3) begin
            plan_op(rand_func(FUNC_SPARE_FIRST, FUNC_SPARE_LAST),
                    $urandom_range(127), rand_word());
         end else if (pick < 10) begin
            // Arbitrary position, mostly out of range
            plan_op(rand_func(0, sal_pkg::OP_READ), $urandom_range(127), rand_word());
         end else begin
            pick = $urandom_range(99);
            if (pick < grow_pct) begin
               if ($urandom_range(1)) begin
                  plan_op(sal_pkg::OP_APPEND, $urandom_range(127), rand_word());
               end else begin
                  plan_op(sal_pkg::OP_INSERT, $urandom_range(plan_fill), rand_word());
               end
            end else begin
               pos = (plan_fill == 0) ? 0 : $urandom_range(plan_fill - 1);
               if (pick < grow_pct + shrink_pct) begin
                  if ($urandom_range(1)) begin
                     plan_op(sal_pkg::OP_POP, $urandom_range(127), rand_word());
                  end else begin
                     plan_op(sal_pkg::OP_REMOVE_AT, pos, rand_word());
                  end
               end else begin
                  plan_op(sal_pkg::OP_READ, pos, rand_word());
               end
            end
         end
      end

      // Wait for every word to be taken and every result to come back
      @(negedge reset);
      while (pending_ops.size() != 0 || req_if.valid) @(posedge clock);
      while (predicted_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d list operations, checked %0d results (%0d full, %0d empty)",
               ops_accepted, rsp_checked, full_seen, empty_seen);
      $display("Rejected: %0d out of range, %0d on full list, %0d on empty list; %0d errors",
               range_rejects, full_rejects, empty_rejects, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
